// ----- hw/rtl/fragment_depth_texture_blend_defines.svh -----
// Assertion macros for the fragment pipeline
`ifndef FRAGMENT_DEPTH_TEXTURE_BLEND_DEFINES_SVH
`define FRAGMENT_DEPTH_TEXTURE_BLEND_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FDTB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FDTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fdtb_pkg.sv -----
`timescale 1ns / 1ps

package fdtb_pkg;

    // Depth test codes
    localparam logic [2:0] DM_NEVER    = 3'd0;
    localparam logic [2:0] DM_LESS     = 3'd1;
    localparam logic [2:0] DM_EQUAL    = 3'd2;
    localparam logic [2:0] DM_LEQUAL   = 3'd3;
    localparam logic [2:0] DM_GREATER  = 3'd4;
    localparam logic [2:0] DM_NOTEQUAL = 3'd5;
    localparam logic [2:0] DM_GEQUAL   = 3'd6;
    localparam logic [2:0] DM_ALWAYS   = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [1:0] CFG_BLEND_ENABLE = 2'd1;
    localparam logic [1:0] CFG_TEXTURE_MASK = 2'd2;

    // Texel inputs present on the ports
    localparam int TEXEL_PORTS = 2;

    // One fragment in flight
    typedef struct packed {
        logic                           pass;
        logic [31:0]                    colour;
        logic [31:0]                    dest;
        logic signed [31:0]             src_depth;
        logic signed [31:0]             dest_depth;
        logic [TEXEL_PORTS-1:0][31:0]   texel;
    } frag_t;

    // Depth comparison, src OP dest, signed
    function automatic logic depth_pass(input logic [2:0] mode,
                                        input logic signed [31:0] s,
                                        input logic signed [31:0] d);
        logic r;
        unique case (mode)
            DM_NEVER:    r = 1'b0;
            DM_LESS:     r = (s < d);
            DM_EQUAL:    r = (s == d);
            DM_LEQUAL:   r = (s <= d);
            DM_GREATER:  r = (s > d);
            DM_NOTEQUAL: r = (s != d);
            DM_GEQUAL:   r = (s >= d);
            DM_ALWAYS:   r = 1'b1;
            default:     r = 1'b1;
        endcase
        return r;
    endfunction

    // Channelwise (c*t)>>8
    function automatic logic [31:0] modulate(input logic [31:0] c, input logic [31:0] t);
        logic [31:0] r;
        logic [15:0] p;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            p = c[k*8 +: 8] * t[k*8 +: 8];
            r[k*8 +: 8] = p[15:8];
        end
        return r;
    endfunction

    // Alpha blend of source over stored colour
    function automatic logic [31:0] blend(input logic [31:0] src, input logic [31:0] dst);
        logic [31:0] r;
        logic [7:0]  a;
        logic [7:0]  ia;
        logic [16:0] sum;
        a  = src[31:24];
        ia = 8'hFF - a;
        for (int k = 0; k < 3; k++) begin
            sum = 17'(dst[k*8 +: 8] * ia) + 17'(src[k*8 +: 8] * a);
            r[k*8 +: 8] = sum[15:8];
        end
        sum = 17'(dst[31:24] * ia) + {1'b0, a, 8'h00};
        r[31:24] = sum[15:8];
        return r;
    endfunction

endpackage

// ----- hw/rtl/fragment_depth_texture_blend.sv -----
`timescale 1ns / 1ps
`include "fragment_depth_texture_blend_defines.svh"

// Fragment depth test, texture modulation and alpha blend. One fragment is
// taken per clock while in_ready is high. Its result passes through one
// register stage for the depth compare, loaded at the accepting edge, one
// per texture unit (capped at TEXEL_PORTS) for its channel multiplies, and
// the output register, which holds the blend multiply-add. Each stage
// moves on when the one after it is empty or moving, so a stall on the
// output side fills the bubbles first and then holds every stage; in_ready
// falls only when all stages are full.
// Configuration writes are taken in any cycle (cfg_ready is always high)
// and must be issued only while no fragment is in flight.
module fragment_depth_texture_blend #(
    parameter int TEXTURE_UNITS = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    // fragment input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        src_rgba,
    input  logic signed [31:0] src_depth,
    input  logic [31:0]        dest_rgba,
    input  logic signed [31:0] dest_depth,
    input  logic [31:0]        texel_zero,
    input  logic [31:0]        texel_one,
    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output logic               write_enable,
    output logic [31:0]        out_rgba,
    output logic signed [31:0] out_depth,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Modulation stages actually built
    localparam int NUM_MOD = (TEXTURE_UNITS < fdtb_pkg::TEXEL_PORTS) ?
                             TEXTURE_UNITS : fdtb_pkg::TEXEL_PORTS;

    logic [2:0] depth_mode_reg;
    logic       blend_enable_reg;
    logic [1:0] texture_mask_reg;

    fdtb_pkg::frag_t          pipe_reg  [NUM_MOD+1];
    logic [NUM_MOD:0]         valid_reg;
    logic [NUM_MOD+1:0]       stage_ready;
    logic                     out_valid_reg;
    logic                     out_we_reg;
    logic [31:0]              out_rgba_reg;
    logic signed [31:0]       out_depth_reg;
    fdtb_pkg::frag_t          frag_next;
    logic [31:0]              blend_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg   <= fdtb_pkg::DM_LESS;
            blend_enable_reg <= 1'b0;
            texture_mask_reg <= 2'b00;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fdtb_pkg::CFG_DEPTH_MODE:   depth_mode_reg   <= cfg_data[2:0];
                fdtb_pkg::CFG_BLEND_ENABLE: blend_enable_reg <= cfg_data[0];
                fdtb_pkg::CFG_TEXTURE_MASK: texture_mask_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Ready chain, output end first
    assign stage_ready[NUM_MOD+1] = !out_valid_reg || out_ready;

    for (genvar k = 0; k <= NUM_MOD; k++) begin : g_ready
        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
    end

    assign in_ready = stage_ready[0];

    // Stage 0: depth compare
    always_comb
    begin
        frag_next.pass       = fdtb_pkg::depth_pass(depth_mode_reg, src_depth, dest_depth);
        frag_next.colour     = src_rgba;
        frag_next.dest       = dest_rgba;
        frag_next.src_depth  = src_depth;
        frag_next.dest_depth = dest_depth;
        frag_next.texel[0]   = texel_zero;
        frag_next.texel[1]   = texel_one;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (stage_ready[0])
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && in_valid)
            pipe_reg[0] <= frag_next;
    end

    // One stage per texture unit, capped at TEXEL_PORTS
    for (genvar m = 0; m < NUM_MOD; m++) begin : g_mod
        fdtb_pkg::frag_t mod_next;

        always_comb
        begin
            mod_next = pipe_reg[m];
            if (pipe_reg[m].pass && texture_mask_reg[m])
                mod_next.colour = fdtb_pkg::modulate(pipe_reg[m].colour,
                                                     pipe_reg[m].texel[m]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[m+1] <= 1'b0;
            else if (stage_ready[m+1])
                valid_reg[m+1] <= valid_reg[m];
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[m+1] && valid_reg[m])
                pipe_reg[m+1] <= mod_next;
        end
    end

    // Output stage: blend or overwrite, pass-through on failed test
    assign blend_next = fdtb_pkg::blend(pipe_reg[NUM_MOD].colour, pipe_reg[NUM_MOD].dest);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_ready[NUM_MOD+1])
            out_valid_reg <= valid_reg[NUM_MOD];
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[NUM_MOD+1] && valid_reg[NUM_MOD])
        begin
            out_we_reg <= pipe_reg[NUM_MOD].pass;
            if (!pipe_reg[NUM_MOD].pass)
            begin
                out_rgba_reg  <= pipe_reg[NUM_MOD].dest;
                out_depth_reg <= pipe_reg[NUM_MOD].dest_depth;
            end
            else
            begin
                out_rgba_reg  <= blend_enable_reg ? blend_next : pipe_reg[NUM_MOD].colour;
                out_depth_reg <= pipe_reg[NUM_MOD].src_depth;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = out_we_reg;
    assign out_rgba     = out_rgba_reg;
    assign out_depth    = out_depth_reg;

    // Input is held back only when every stage is occupied
    `FDTB_ASSERT_NOW(a_full_when_blocked, !in_ready, (&valid_reg) && out_valid_reg,
                     "input stalled with a bubble in the pipeline")

    // A fragment waiting in the last stage is neither lost nor altered
    `FDTB_ASSERT_NEXT(a_last_stage_holds,
                      valid_reg[NUM_MOD] && !stage_ready[NUM_MOD+1],
                      valid_reg[NUM_MOD] && $stable(pipe_reg[NUM_MOD]),
                      "stalled fragment dropped or changed")

    // Entry stage holds under back-pressure
    `FDTB_ASSERT_NEXT(a_entry_holds, valid_reg[0] && !stage_ready[1],
                      valid_reg[0] && $stable(pipe_reg[0]),
                      "entry stage lost a fragment under stall")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_LATENCY = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 4;
    localparam int BLOCKS       = 5;
    localparam int CHAN_MAX     = 255;
    localparam int CHAN_SHIFT   = 8;

    // index 3 is decoded by nothing
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] DEPTH_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [31:0]        src_rgba;
        logic signed [31:0] src_depth;
        logic [31:0]        dest_rgba;
        logic signed [31:0] dest_depth;
        logic [31:0]        texel_zero;
        logic [31:0]        texel_one;
    } fragment_t;

    typedef struct {
        logic               wr_en;
        logic [31:0]        rgba;
        logic signed [31:0] depth;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        src_rgba;
    logic signed [31:0] src_depth;
    logic [31:0]        dest_rgba;
    logic signed [31:0] dest_depth;
    logic [31:0]        texel_zero;
    logic [31:0]        texel_one;
    logic               out_valid;
    logic               out_ready;
    logic               write_enable;
    logic [31:0]        out_rgba;
    logic signed [31:0] out_depth;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    // shadow copy of the registers, reset values
    logic [2:0] mode_shadow  = fdtb_pkg::DM_LESS;
    logic       blend_shadow = 1'b0;
    logic [1:0] mask_shadow  = 2'b00;

    pixel_t expected_pixels[$];
    int     errors        = 0;
    int     cycle_count   = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_cycles   = 0;

    fragment_depth_texture_blend u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_rgba     (src_rgba),
        .src_depth    (src_depth),
        .dest_rgba    (dest_rgba),
        .dest_depth   (dest_depth),
        .texel_zero   (texel_zero),
        .texel_one    (texel_one),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .out_rgba     (out_rgba),
        .out_depth    (out_depth),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // pixel predictor
    // ---------------------------------------------------------------

    // signed compare, fragment depth against stored depth
    function automatic logic depth_passes(logic signed [31:0] s, logic signed [31:0] d);
        logic ok;
        case (mode_shadow)
            fdtb_pkg::DM_NEVER:    ok = 1'b0;
            fdtb_pkg::DM_LESS:     ok = s < d;
            fdtb_pkg::DM_EQUAL:    ok = s == d;
            fdtb_pkg::DM_LEQUAL:   ok = s <= d;
            fdtb_pkg::DM_GREATER:  ok = s > d;
            fdtb_pkg::DM_NOTEQUAL: ok = s != d;
            fdtb_pkg::DM_GEQUAL:   ok = s >= d;
            default:               ok = 1'b1;
        endcase
        return ok;
    endfunction

    // per channel (c*t)>>8
    function automatic logic [31:0] tint(logic [31:0] c, logic [31:0] t);
        logic [31:0] r;
        for (int k = 0; k < 4; k++)
            r[8*k +: 8] = 8'((int'(c[8*k +: 8]) * int'(t[8*k +: 8])) >> CHAN_SHIFT);
        return r;
    endfunction

    // source over stored colour, weighted by source alpha
    function automatic logic [31:0] blend_over(logic [31:0] src, logic [31:0] dst);
        logic [31:0] r;
        int          alpha;
        int          inv;
        alpha = int'(src[31:24]);
        inv   = CHAN_MAX - alpha;
        for (int k = 0; k < 3; k++)
            r[8*k +: 8] = 8'((int'(dst[8*k +: 8]) * inv + int'(src[8*k +: 8]) * alpha)
                             >> CHAN_SHIFT);
        r[31:24] = 8'((int'(dst[31:24]) * inv + (alpha << CHAN_SHIFT)) >> CHAN_SHIFT);
        return r;
    endfunction

    function automatic pixel_t predict_pixel(fragment_t f);
        pixel_t      p;
        logic [31:0] c;
        if (!depth_passes(f.src_depth, f.dest_depth))
        begin
            p.wr_en = 1'b0;
            p.rgba  = f.dest_rgba;
            p.depth = f.dest_depth;
            return p;
        end
        c = f.src_rgba;
        if (mask_shadow[0])
            c = tint(c, f.texel_zero);
        if (mask_shadow[1])
            c = tint(c, f.texel_one);
        if (blend_shadow)
            c = blend_over(c, f.dest_rgba);
        p.wr_en = 1'b1;
        p.rgba  = c;
        p.depth = f.src_depth;
        return p;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic write_register(logic [1:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // only the low bits of each register are kept
        case (index)
            fdtb_pkg::CFG_DEPTH_MODE:   mode_shadow  = data[2:0];
            fdtb_pkg::CFG_BLEND_ENABLE: blend_shadow = data[0];
            fdtb_pkg::CFG_TEXTURE_MASK: mask_shadow  = data[1:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one fragment transaction; valid is left high for a back-to-back follower
    task automatic send_fragment(fragment_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        src_rgba   <= f.src_rgba;
        src_depth  <= f.src_depth;
        dest_rgba  <= f.dest_rgba;
        dest_depth <= f.dest_depth;
        texel_zero <= f.texel_zero;
        texel_one  <= f.texel_one;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pixels.push_back(predict_pixel(f));
    endtask

    // stop sending and let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    function automatic fragment_t random_fragment();
        fragment_t f;
        f.src_rgba   = $urandom;
        f.src_depth  = $urandom;
        f.dest_rgba  = $urandom;
        f.texel_zero = $urandom;
        f.texel_one  = $urandom;
        // bias the stored depth towards ties and near misses
        case ($urandom_range(3))
            0: f.dest_depth = $urandom;
            1: f.dest_depth = f.src_depth;
            2: f.dest_depth = f.src_depth + int'($urandom_range(4)) - 2;
            default:
            begin
                f.src_depth  = $urandom_range(1) ? DEPTH_MIN : DEPTH_MAX;
                f.dest_depth = $urandom_range(1) ? DEPTH_MIN : DEPTH_MAX;
            end
        endcase
        // transparent and opaque alpha
        case ($urandom_range(3))
            0:       f.src_rgba[31:24] = 8'h00;
            1:       f.src_rgba[31:24] = 8'hFF;
            default: ;
        endcase
        return f;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stalls, or a long hold-off when asked
    // ---------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_pixel
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: write_enable %b out_rgba %h out_depth %h",
                       write_enable, out_rgba, out_depth);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (write_enable !== want.wr_en)
                begin
                    $error("write_enable: expected %b, actual %b", want.wr_en, write_enable);
                    errors++;
                end
                if (out_rgba !== want.rgba)
                begin
                    $error("out_rgba: expected %h, actual %h", want.rgba, out_rgba);
                    errors++;
                end
                if (out_depth !== want.depth)
                begin
                    $error("out_depth: expected %h, actual %h", want.depth, out_depth);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // registers untouched: less-than test, plain overwrite, no texturing
    task automatic test_reset_defaults();
        send_fragment('{32'hFFFF_FFFF, DEPTH_MIN, 32'h0000_0000, DEPTH_MAX,
                        32'h0000_0000, 32'h0000_0000});
        send_fragment('{32'h0000_0000, 32'sd5, 32'hFFFF_FFFF, 32'sd5,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF});
        settle();
    endtask

    // every compare against below, equal and above
    task automatic test_depth_modes();
        logic [2:0] modes[8];
        modes = '{fdtb_pkg::DM_NEVER, fdtb_pkg::DM_LESS, fdtb_pkg::DM_EQUAL,
                  fdtb_pkg::DM_LEQUAL, fdtb_pkg::DM_GREATER, fdtb_pkg::DM_NOTEQUAL,
                  fdtb_pkg::DM_GEQUAL, fdtb_pkg::DM_ALWAYS};
        foreach (modes[m])
        begin
            write_register(fdtb_pkg::CFG_DEPTH_MODE, 32'(modes[m]));
            send_fragment('{$urandom, DEPTH_MIN, $urandom, DEPTH_MAX, $urandom, $urandom});
            send_fragment('{$urandom, -32'sd1, $urandom, -32'sd1, $urandom, $urandom});
            send_fragment('{$urandom, 32'sd0, $urandom, -32'sd1, $urandom, $urandom});
            settle();
        end
    endtask

    // each texture mask with and without blending, depth test always passing
    task automatic test_texture_blend();
        write_register(fdtb_pkg::CFG_DEPTH_MODE, 32'(fdtb_pkg::DM_ALWAYS));
        for (int mask = 0; mask < 4; mask++)
        begin
            for (int bl = 0; bl < 2; bl++)
            begin
                write_register(fdtb_pkg::CFG_TEXTURE_MASK, 32'(mask));
                write_register(fdtb_pkg::CFG_BLEND_ENABLE, 32'(bl));
                send_fragment('{32'hFFFF_FFFF, DEPTH_MAX, 32'h1234_5678, DEPTH_MIN,
                                32'h80FF_0001, 32'hFF00_FF7F});
                settle();
            end
        end
    endtask

    // high data bits dropped, write to the undecoded index has no effect
    task automatic test_register_width();
        write_register(fdtb_pkg::CFG_DEPTH_MODE, 32'hFFFF_FFF8 | 32'(fdtb_pkg::DM_EQUAL));
        write_register(fdtb_pkg::CFG_BLEND_ENABLE, 32'hFFFF_FFFF);
        write_register(fdtb_pkg::CFG_TEXTURE_MASK, 32'hFFFF_FFFE);
        write_register(CFG_UNMAPPED, $urandom);
        send_fragment('{32'h7F80_C040, 32'sd100, 32'h8040_2010, 32'sd100,
                        32'hFFFF_FFFF, 32'h80A0_C0E0});
        send_fragment('{32'h7F80_C040, 32'sd100, 32'h8040_2010, 32'sd101,
                        32'hFFFF_FFFF, 32'h80A0_C0E0});
        settle();
    endtask

    // output held off long enough to back the pipe up into the input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_register(fdtb_pkg::CFG_DEPTH_MODE, 32'(fdtb_pkg::DM_GEQUAL));
        write_register(fdtb_pkg::CFG_BLEND_ENABLE, 32'(1));
        write_register(fdtb_pkg::CFG_TEXTURE_MASK, 32'(3));
        @(posedge clk);
        hold_cycles = 50;
        for (int i = 0; i < 24; i++)
            send_fragment(random_fragment());
        // sender waits for every result before going on
        settle();
        for (int i = 0; i < 8; i++)
            send_fragment(random_fragment());
        settle();
    endtask

    // random fragments across idling phases and register settings
    task automatic test_random_stream();
        int idle_pct[PHASES];
        int stall_pct[PHASES];
        int per_block;
        idle_pct  = '{0, 57, 0, 21};
        stall_pct = '{0, 0, 57, 21};
        per_block = RANDOM_ITEMS / (PHASES * BLOCKS);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            for (int b = 0; b < BLOCKS; b++)
            begin
                write_register(fdtb_pkg::CFG_DEPTH_MODE,
                               ($urandom & 32'hFFFF_FFF8) | $urandom_range(7));
                write_register(fdtb_pkg::CFG_BLEND_ENABLE, $urandom);
                write_register(fdtb_pkg::CFG_TEXTURE_MASK, $urandom);
                for (int i = 0; i < per_block; i++)
                    send_fragment(random_fragment());
                settle();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        src_rgba   = '0;
        src_depth  = '0;
        dest_rgba  = '0;
        dest_depth = '0;
        texel_zero = '0;
        texel_one  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = fdtb_pkg::CFG_DEPTH_MODE;
        cfg_data   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_depth_modes();
        test_texture_blend();
        test_register_width();
        test_backpressure();
        test_random_stream();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- fragment_depth_texture_blend.f -----
+incdir+hw/rtl
hw/rtl/fdtb_pkg.sv
hw/rtl/fragment_depth_texture_blend.sv
verif/tb.sv
